// ===== rtl/event_subscription_matcher_assert.svh =====
// Assertion macros shared by the event subscription matcher RTL.
`ifndef EVENT_SUBSCRIPTION_MATCHER_ASSERT_SVH
`define EVENT_SUBSCRIPTION_MATCHER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define ESM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define ESM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESM_ASSERT(lbl, prop, msg)
`define ESM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/esm_pkg.sv =====
// Shared constants, types and functions of the event subscription matcher.
package esm_pkg;

	// Table geometry.
	localparam int SLOTS = 32;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = IDX_W + 1;

	// Field widths.
	localparam int CODE_W = 32;
	localparam int ID_W = 17;
	localparam int HANDLE_W = 16;
	localparam int LG_W = 4;
	localparam int BKT_W = 10;
	localparam logic [LG_W-1:0] LG_MAX = LG_W'(BKT_W);

	// Request kinds.
	localparam logic [1:0] KIND_SUBSCRIBE = 2'd0;
	localparam logic [1:0] KIND_UNSUBSCRIBE = 2'd1;
	localparam logic [1:0] KIND_EMIT = 2'd2;
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	// Result kinds.
	localparam logic [1:0] RES_PROXY = 2'd0;
	localparam logic [1:0] RES_MATCH = 2'd1;
	localparam logic [1:0] RES_DONE = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BUCKET_LG = 2'd0;
	localparam logic [1:0] REG_WILDCARD = 2'd1;
	localparam logic [1:0] REG_PROXY_EN = 2'd2;

	// One stored subscription.
	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic [ID_W-1:0] emitter;
		logic [ID_W-1:0] target;
		logic [ID_W-1:0] target_kind;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic walk_start;
		logic walk_next;
		logic sub_write;
		logic copy_write;
		logic cnt_dec;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic full;
		logic last_entry;
		logic match;
		logic hit;
		logic proxy_fwd;
		logic [HANDLE_W-1:0] next_handle;
		logic [HANDLE_W-1:0] entry_handle;
		logic [HANDLE_W-1:0] req_handle;
	} dp_stat_t;

	// Bucket of an event code: XOR fold of its bytes, masked to its low lg bits (lg capped at LG_MAX).
	function automatic logic [BKT_W-1:0] bucket_of(input logic [CODE_W-1:0] code,
			input logic [LG_W-1:0] lg);
		logic [CODE_W-1:0] fold;
		logic [LG_W-1:0] lim;
		logic [BKT_W-1:0] mask;
		fold = code ^ (code >> 8) ^ (code >> 16) ^ (code >> 24);
		lim = (lg > LG_MAX) ? LG_MAX : lg;
		for (int i = 0; i < BKT_W; i++) begin
			mask[i] = (LG_W'(i) < lim);
		end
		return fold[BKT_W-1:0] & mask;
	endfunction

endpackage

// ===== rtl/event_subscription_matcher.sv =====
// Top level of the event subscription matcher.
// The block keeps up to 32 subscriptions in insertion order in a table with one write port
// and a registered read port, and handles one request at a time. A subscribe request places
// its done result in the output register from the S_SUB state that follows its acceptance.
// An unsubscribe request searches and then compacts the table one entry per cycle, and an
// emit request walks the table one entry per cycle through the read port while no match
// result waits for a stalled output register. A result that waits for a stalled output
// register holds the request in its state. Requests are taken again once the final result
// has been placed in the output register. Kind 3 requests are accepted and dropped.
`include "event_subscription_matcher_assert.svh"

module event_subscription_matcher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       kind,
	input  logic [31:0]                      event_code,
	input  logic signed [16:0]               emitter_id,
	input  logic signed [16:0]               target_id,
	input  logic signed [16:0]               target_kind,
	input  logic                             proxied,
	input  logic [15:0]                      handle_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       result_kind,
	output logic [15:0]                      handle_out,
	output logic [1:0]                       status,
	output logic                             last,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [31:0]                      cfg_data
);

	esm_pkg::ctrl_cmd_t cmd;
	esm_pkg::dp_stat_t dp_st;

	// Sequencing of requests and results.
	esm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.handle_out  (handle_out),
		.status      (status),
		.last        (last),
		.cmd         (cmd),
		.dp_st       (dp_st)
	);

	// Table, counters and matching.
	esm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_code  (event_code),
		.emitter_id  (emitter_id),
		.target_id   (target_id),
		.target_kind (target_kind),
		.proxied     (proxied),
		.handle_in   (handle_in),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.dp_st       (dp_st)
	);

	// A real request keeps the input side stalled on the following cycle.
	`ESM_ASSERT(a_busy_after_accept, in_valid && !in_stall && (kind != esm_pkg::KIND_RESERVED) |=> in_stall, "request accepted but input not stalled")
	// The final result of a request is always a done result.
	`ESM_ASSERT(a_last_is_done, out_valid && last |-> (result_kind == esm_pkg::RES_DONE), "last result is not a done result")
	// A full table is never written by a subscribe.
	`ESM_ASSERT_ALWAYS(a_no_write_full, !(cmd.sub_write && dp_st.full), "subscribe written to a full table")
	// The entry count never goes below zero.
	`ESM_ASSERT_ALWAYS(a_no_dec_empty, !(cmd.cnt_dec && dp_st.count_zero), "entry count decremented from zero")

endmodule

// ===== rtl/esm_ctrl.sv =====
// Controller state machine of the event subscription matcher, with the result register.
module esm_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       kind,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       result_kind,
	output logic [esm_pkg::HANDLE_W-1:0]     handle_out,
	output logic [1:0]                       status,
	output logic                             last,
	output esm_pkg::ctrl_cmd_t               cmd,
	input  esm_pkg::dp_stat_t                dp_st
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUB,
		S_EPROXY,
		S_ECHK,
		S_EDONE,
		S_USTART,
		S_USRCH,
		S_UCOPY,
		S_UDONE
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic [1:0] res_kind_q;
	logic [esm_pkg::HANDLE_W-1:0] res_handle_q;
	logic [1:0] res_status_q;
	logic res_last_q;
	logic [1:0] ustat_q, ustat_d;

	logic out_free;
	logic accept;
	logic place;
	logic [1:0] p_kind;
	logic [esm_pkg::HANDLE_W-1:0] p_handle;
	logic [1:0] p_status;
	logic p_last;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);

	// Next state, datapath commands and the result to place.
	always_comb begin
		state_d = state_q;
		ustat_d = ustat_q;
		cmd = '0;
		place = 1'b0;
		p_kind = esm_pkg::RES_DONE;
		p_handle = '0;
		p_status = esm_pkg::ST_OK;
		p_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = accept;
				if (accept) begin
					unique case (kind)
						esm_pkg::KIND_SUBSCRIBE: state_d = S_SUB;
						esm_pkg::KIND_UNSUBSCRIBE: state_d = S_USTART;
						esm_pkg::KIND_EMIT: state_d = S_EPROXY;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SUB: begin
				if (out_free) begin
					place = 1'b1;
					p_last = 1'b1;
					if (dp_st.full) begin
						p_status = esm_pkg::ST_FULL;
					end else begin
						p_handle = dp_st.next_handle;
						cmd.sub_write = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_EPROXY: begin
				if (out_free) begin
					if (dp_st.proxy_fwd) begin
						place = 1'b1;
						p_kind = esm_pkg::RES_PROXY;
					end
					if (dp_st.count_zero) begin
						state_d = S_EDONE;
					end else begin
						cmd.walk_start = 1'b1;
						state_d = S_ECHK;
					end
				end
			end
			S_ECHK: begin
				if (!dp_st.match || out_free) begin
					if (dp_st.match) begin
						place = 1'b1;
						p_kind = esm_pkg::RES_MATCH;
						p_handle = dp_st.entry_handle;
					end
					if (dp_st.last_entry) begin
						state_d = S_EDONE;
					end else begin
						cmd.walk_next = 1'b1;
					end
				end
			end
			S_EDONE: begin
				if (out_free) begin
					place = 1'b1;
					p_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_USTART: begin
				if (dp_st.count_zero) begin
					ustat_d = esm_pkg::ST_NOT_FOUND;
					state_d = S_UDONE;
				end else begin
					cmd.walk_start = 1'b1;
					state_d = S_USRCH;
				end
			end
			S_USRCH: begin
				if (dp_st.hit) begin
					if (dp_st.last_entry) begin
						cmd.cnt_dec = 1'b1;
						ustat_d = esm_pkg::ST_OK;
						state_d = S_UDONE;
					end else begin
						cmd.walk_next = 1'b1;
						state_d = S_UCOPY;
					end
				end else if (dp_st.last_entry) begin
					ustat_d = esm_pkg::ST_NOT_FOUND;
					state_d = S_UDONE;
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			S_UCOPY: begin
				// Move the entry just read down by one place to close the gap.
				cmd.copy_write = 1'b1;
				if (dp_st.last_entry) begin
					cmd.cnt_dec = 1'b1;
					ustat_d = esm_pkg::ST_OK;
					state_d = S_UDONE;
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			S_UDONE: begin
				if (out_free) begin
					place = 1'b1;
					p_last = 1'b1;
					p_handle = dp_st.req_handle;
					p_status = ustat_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ustat_q <= esm_pkg::ST_OK;
			out_valid_q <= 1'b0;
			res_kind_q <= esm_pkg::RES_DONE;
			res_handle_q <= '0;
			res_status_q <= esm_pkg::ST_OK;
			res_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ustat_q <= ustat_d;
			if (place) begin
				out_valid_q <= 1'b1;
				res_kind_q <= p_kind;
				res_handle_q <= p_handle;
				res_status_q <= p_status;
				res_last_q <= p_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = res_kind_q;
	assign handle_out = res_handle_q;
	assign status = res_status_q;
	assign last = res_last_q;

endmodule

// ===== rtl/esm_datapath.sv =====
// Datapath of the event subscription matcher: subscription table, counters, match logic.
module esm_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [esm_pkg::CODE_W-1:0]       event_code,
	input  logic [esm_pkg::ID_W-1:0]         emitter_id,
	input  logic [esm_pkg::ID_W-1:0]         target_id,
	input  logic [esm_pkg::ID_W-1:0]         target_kind,
	input  logic                             proxied,
	input  logic [esm_pkg::HANDLE_W-1:0]     handle_in,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [esm_pkg::CODE_W-1:0]       cfg_data,
	input  esm_pkg::ctrl_cmd_t               cmd,
	output esm_pkg::dp_stat_t                dp_st
);

	localparam int IW = esm_pkg::IDX_W;
	localparam int CW = esm_pkg::CNT_W;

	// Configuration registers.
	logic [esm_pkg::LG_W-1:0] lg_q;
	logic [esm_pkg::CODE_W-1:0] wc_q;
	logic pe_q;

	// Latched request fields.
	logic [esm_pkg::CODE_W-1:0] code_q;
	logic [esm_pkg::ID_W-1:0] emi_q;
	logic [esm_pkg::ID_W-1:0] tgt_q;
	logic [esm_pkg::ID_W-1:0] tk_q;
	logic prox_q;
	logic [esm_pkg::HANDLE_W-1:0] hin_q;

	// Table state.
	esm_pkg::entry_t mem [esm_pkg::SLOTS];
	esm_pkg::entry_t rd_q;
	logic [CW-1:0] count_q;
	logic [esm_pkg::HANDLE_W-1:0] nh_q;
	logic [IW-1:0] ptr_q;

	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	esm_pkg::entry_t wr_data;
	logic bkt_ok;
	logic code_ok;
	logic ids_ok;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= esm_pkg::LG_W'(4);
			wc_q <= '1;
			pe_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esm_pkg::REG_BUCKET_LG: lg_q <= cfg_data[esm_pkg::LG_W-1:0];
				esm_pkg::REG_WILDCARD: wc_q <= cfg_data;
				esm_pkg::REG_PROXY_EN: pe_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Request fields are captured when the request is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= event_code;
			emi_q <= emitter_id;
			tgt_q <= target_id;
			tk_q <= target_kind;
			prox_q <= proxied;
			hin_q <= handle_in;
		end
	end

	// Entry count, handle counter and walk pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			nh_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.sub_write) begin
				count_q <= count_q + 1'b1;
				nh_q <= nh_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.walk_start) begin
				ptr_q <= '0;
			end else if (cmd.walk_next) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Table ports: one write, one registered read.
	assign rd_en = cmd.walk_start || cmd.walk_next;
	assign rd_addr = cmd.walk_start ? '0 : ptr_q + 1'b1;
	assign wr_en = cmd.sub_write || cmd.copy_write;
	assign wr_addr = cmd.sub_write ? count_q[IW-1:0] : ptr_q - 1'b1;

	always_comb begin
		if (cmd.sub_write) begin
			wr_data.event_code = code_q;
			wr_data.emitter = emi_q;
			wr_data.target = tgt_q;
			wr_data.target_kind = tk_q;
			wr_data.handle = nh_q;
		end else begin
			wr_data = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Match of the entry currently read against the latched event.
	assign bkt_ok = esm_pkg::bucket_of(rd_q.event_code, lg_q)
			== esm_pkg::bucket_of(code_q, lg_q);
	assign code_ok = (rd_q.event_code == wc_q) || (rd_q.event_code == code_q);
	assign ids_ok = ((rd_q.emitter == '1) || (rd_q.emitter == emi_q))
			&& ((rd_q.target == '1) || (rd_q.target == tgt_q))
			&& ((rd_q.target_kind == '1) || (rd_q.target_kind == tk_q));

	// Status towards the controller.
	always_comb begin
		dp_st.count_zero = (count_q == '0);
		dp_st.full = (count_q == CW'(esm_pkg::SLOTS));
		dp_st.last_entry = ((CW'(ptr_q) + 1'b1) >= count_q);
		dp_st.match = bkt_ok && code_ok && ids_ok;
		dp_st.hit = (rd_q.handle == hin_q);
		dp_st.proxy_fwd = pe_q && !prox_q;
		dp_st.next_handle = nh_q;
		dp_st.entry_handle = rd_q.handle;
		dp_st.req_handle = hin_q;
	end

endmodule
